### design/comment_stripper_assert.svh
`ifndef COMMENT_STRIPPER_ASSERT_SVH
`define COMMENT_STRIPPER_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define CS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define CS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cs_pkg.sv
package cs_pkg;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_HELD      = 3'd1,
        MODE_BLOCK     = 3'd2,
        MODE_BLOCK_STAR = 3'd3,
        MODE_LINE      = 3'd4,
        MODE_ATTR      = 3'd5,
        MODE_ATTR_STAR = 3'd6
    } mode_t;

    // Characters of interest
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Held opener codes
    localparam logic HELD_SLASH = 1'b0;
    localparam logic HELD_OPEN  = 1'b1;

    // One classified input item: one or two results for the back end
    typedef struct packed {
        logic [7:0] byte0;
        logic       has0;   // 0 only for a bare end marker
        logic [7:0] byte1;
        logic       two;    // second result present
        logic       last;   // item closes the text
    } entry_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage

### design/cs_front.sv
module cs_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           q_full,
    output logic           in_ready,
    output logic           push,
    output cs_pkg::entry_t push_entry
);
    import cs_pkg::*;

    mode_t mode_reg, mode_next;
    logic  held_reg, held_next;
    logic  accept;
    logic  plain_hold;
    logic  emit_n0, emit_n1;   // results before the end-marker fill

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Hold a slash or open paren unless this is the final byte
    assign plain_hold = !in_last && (in_byte == CH_SLASH || in_byte == CH_OPEN);

    // Classify the byte and compute the next mode
    always_comb begin
        mode_next = mode_reg;
        held_next = held_reg;
        emit_n0   = 1'b0;
        emit_n1   = 1'b0;
        push_entry = '0;
        case (mode_reg)
            MODE_HELD: begin
                if (held_reg == HELD_SLASH && in_byte == CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end else if (held_reg == HELD_SLASH && in_byte == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (held_reg == HELD_OPEN && in_byte == CH_STAR) begin
                    mode_next = MODE_ATTR;
                end else begin
                    emit_n0 = 1'b1;
                    push_entry.byte0 = (held_reg == HELD_OPEN) ? CH_OPEN : CH_SLASH;
                    if (plain_hold) begin
                        mode_next = MODE_HELD;
                        held_next = (in_byte == CH_OPEN);
                    end else begin
                        emit_n1 = 1'b1;
                        push_entry.byte1 = in_byte;
                        mode_next = MODE_NORMAL;
                    end
                end
            end
            MODE_BLOCK, MODE_ATTR: begin
                if (in_last) begin
                    emit_n0 = 1'b1;
                    push_entry.byte0 = in_byte;
                end else if (in_byte == CH_STAR) begin
                    mode_next = (mode_reg == MODE_BLOCK) ? MODE_BLOCK_STAR : MODE_ATTR_STAR;
                end
            end
            MODE_BLOCK_STAR, MODE_ATTR_STAR: begin
                if (in_byte == ((mode_reg == MODE_BLOCK_STAR) ? CH_SLASH : CH_CLOSE)) begin
                    mode_next = MODE_NORMAL;
                end else if (in_last) begin
                    emit_n0 = 1'b1;
                    push_entry.byte0 = in_byte;
                end else if (in_byte != CH_STAR) begin
                    mode_next = (mode_reg == MODE_BLOCK_STAR) ? MODE_BLOCK : MODE_ATTR;
                end
            end
            MODE_LINE: begin
                if (in_byte == CH_NEWLINE) begin
                    emit_n0 = 1'b1;
                    push_entry.byte0 = in_byte;
                    mode_next = MODE_NORMAL;
                end
            end
            default: begin
                // Normal text, unused code included
                if (plain_hold) begin
                    mode_next = MODE_HELD;
                    held_next = (in_byte == CH_OPEN);
                end else begin
                    emit_n0 = 1'b1;
                    push_entry.byte0 = in_byte;
                    mode_next = MODE_NORMAL;
                end
            end
        endcase

        push_entry.has0 = emit_n0;
        push_entry.two  = emit_n1;
        push_entry.last = in_last;

        // Close the text: restart the scanner, mark an empty item
        if (in_last) begin
            mode_next = MODE_NORMAL;
            held_next = HELD_SLASH;
        end
    end

    assign push = accept && (emit_n0 || in_last);

    // Advance the scanner on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            held_reg <= HELD_SLASH;
        end else if (accept) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

`include "comment_stripper_assert.svh"

    `CS_ASSERT_NEXT(a_last_restarts, accept && in_last, mode_reg == MODE_NORMAL && held_reg == HELD_SLASH, "scanner not restarted after final byte")
    `CS_ASSERT_NOW(a_second_needs_first, push && push_entry.two, push_entry.has0, "second result without first")

endmodule

### design/cs_queue.sv
module cs_queue #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cs_pkg::entry_t push_entry,
    input  logic           pop,
    output logic           full,
    output cs_pkg::head_t  head
);
    import cs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Store an entry at the tail
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`include "comment_stripper_assert.svh"

    `CS_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
    `CS_ASSERT_NOW(a_no_underflow, pop, count_reg != '0, "pop from empty queue")

endmodule

### design/cs_back.sv
module cs_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  cs_pkg::head_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_has,
    output logic          out_end
);
    import cs_pkg::*;

    logic idx_reg, idx_next;   // 1 while the second result of the head is shown
    logic take;

    assign out_valid = head.valid;
    assign take      = out_valid && out_ready;

    // Select the result of the head entry on show
    always_comb begin
        if (idx_reg) begin
            out_byte = head.entry.byte1;
            out_has  = 1'b1;
            out_end  = head.entry.last;
        end else begin
            out_byte = head.entry.byte0;
            out_has  = head.entry.has0;
            out_end  = head.entry.last && !head.entry.two;
        end
    end

    // Step to the second result or retire the entry
    always_comb begin
        idx_next = idx_reg;
        pop      = 1'b0;
        if (take) begin
            if (!idx_reg && head.entry.two) begin
                idx_next = 1'b1;
            end else begin
                idx_next = 1'b0;
                pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
        end
    end

`include "comment_stripper_assert.svh"

    `CS_ASSERT_NOW(a_second_valid, idx_reg, head.valid && head.entry.two, "second slot shown for single entry")

endmodule

### design/comment_stripper.sv
// Comment stripper: takes a text one byte per transaction on the slave side (s_tlast on the
// final byte) and passes it on with slash-star, slash-slash and paren-star comments removed; a
// line comment keeps its newline. Input is taken at one byte per cycle while the queue has
// room: a scanner classifies each byte in the cycle it is accepted and writes zero, one or
// two results into a queue of QUEUE_DEPTH entries. The output side drains one result per
// cycle while m_tready is high; a byte that releases a held slash or paren yields two results
// in one queue entry, shown one after the other; s_tready drops only while the queue is full.
// m_tuser[0] is 0 on a bare end marker, which carries no byte; m_tlast marks the final result
// of a text. The scanner restarts in plain text after every final byte.
module comment_stripper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] has_byte
    output logic       m_tlast    // end_of_text
);
    import cs_pkg::*;

    logic   push, pop, q_full;
    entry_t push_entry;
    head_t  head;
    logic   out_has;

    // Classify input bytes
    cs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple scanner and output
    cs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head       (head)
    );

    // Emit results
    cs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_has   (out_has),
        .out_end   (m_tlast)
    );

    assign m_tuser = out_has;

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cs_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int DIR_ROWS       = 25;
    localparam int RAND_ITEMS     = 825;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // One character of stripped text as seen on the master side
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eot;
    } strip_res_t;

    // One row of the directed table
    typedef struct packed {
        logic [7:0] chr;
        logic       lst;
        logic       typed;
        logic [1:0] n_res;
        strip_res_t r0;
        strip_res_t r1;
    } dir_row_t;

    localparam strip_res_t NO_RES = '{8'h00, 1'b0, 1'b0};

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    comment_stripper u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] in_byte
        .s_tlast  (s_tlast),   // is_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_byte
        .m_tuser  (m_tuser),   // [0] has_byte
        .m_tlast  (m_tlast)    // end_of_text
    );

    // Free-running clock
    always #CLK_HALF aclk = ~aclk;

    strip_res_t stripped_q [$];
    dir_row_t   dir_tbl [DIR_ROWS];

    mode_t      pred_mode = MODE_NORMAL;
    logic       pred_held = HELD_SLASH;
    strip_res_t step_res [2];
    int         step_cnt;

    bit idle_on     = 1'b1;
    int err_cnt     = 0;
    int bytes_sent  = 0;
    int texts_sent  = 0;
    int res_checked = 0;
    int drain_holds = 0;
    int idle_cycles = 0;
    int stall_left  = 0;

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 4))
            0: return CH_SLASH;
            1: return CH_STAR;
            2: return CH_OPEN;
            3: return CH_CLOSE;
            default: return CH_NEWLINE;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        if ($urandom_range(0, 4) == 0) return pick_special();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_body();
        if ($urandom_range(0, 1) == 0) return pick_special();
        return 8'($urandom_range(0, 255));
    endfunction

    // Stripper model: appends one result of the current byte to step_res
    function automatic void emit_char(input logic [7:0] b, input logic has);
        step_res[step_cnt] = '{b, has, 1'b0};
        step_cnt++;
    endfunction

    // Hold an opener in running text unless the text ends here
    function automatic void plain_char(input logic [7:0] c, input logic lst);
        if (!lst && (c == CH_SLASH || c == CH_OPEN)) begin
            pred_mode = MODE_HELD;
            pred_held = (c == CH_OPEN) ? HELD_OPEN : HELD_SLASH;
        end else begin
            emit_char(c, 1'b1);
            pred_mode = MODE_NORMAL;
        end
    endfunction

    function automatic void strip_step(input logic [7:0] c, input logic lst);
        logic [7:0] closer;
        step_cnt = 0;
        step_res[0] = NO_RES;
        step_res[1] = NO_RES;
        case (pred_mode)
            MODE_HELD: begin
                if (pred_held == HELD_SLASH && c == CH_STAR) begin
                    pred_mode = MODE_BLOCK;
                end else if (pred_held == HELD_SLASH && c == CH_SLASH) begin
                    pred_mode = MODE_LINE;
                end else if (pred_held == HELD_OPEN && c == CH_STAR) begin
                    pred_mode = MODE_ATTR;
                end else begin
                    emit_char((pred_held == HELD_OPEN) ? CH_OPEN : CH_SLASH, 1'b1);
                    plain_char(c, lst);
                end
            end
            MODE_BLOCK, MODE_ATTR: begin
                if (lst) begin
                    emit_char(c, 1'b1);
                end else if (c == CH_STAR) begin
                    pred_mode = mode_t'(pred_mode + 3'd1);
                end
            end
            MODE_BLOCK_STAR, MODE_ATTR_STAR: begin
                closer = (pred_mode == MODE_BLOCK_STAR) ? CH_SLASH : CH_CLOSE;
                if (c == closer) begin
                    pred_mode = MODE_NORMAL;
                end else if (lst) begin
                    emit_char(c, 1'b1);
                end else if (c != CH_STAR) begin
                    pred_mode = mode_t'(pred_mode - 3'd1);
                end
            end
            MODE_LINE: begin
                if (c == CH_NEWLINE) begin
                    emit_char(c, 1'b1);
                    pred_mode = MODE_NORMAL;
                end
            end
            default: begin
                plain_char(c, lst);
            end
        endcase
        // Close the text: bare end marker if nothing else came out
        if (lst) begin
            if (step_cnt == 0) emit_char(8'h00, 1'b0);
            step_res[step_cnt - 1].eot = 1'b1;
            pred_mode = MODE_NORMAL;
            pred_held = HELD_SLASH;
        end
    endfunction

    function automatic void push_step_results();
        for (int k = 0; k < step_cnt; k++) stripped_q = {stripped_q, step_res[k]};
    endfunction

    // Present one byte after a random gap and hold it until the transaction completes
    task automatic drive_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        drive_byte(b, lst);
        strip_step(b, lst);
        push_step_results();
    endtask

    task automatic send_body();
        int len;
        len = $urandom_range(0, 5);
        repeat (len) send_byte(pick_body(), 1'b0);
    endtask

    // Stop sending until the stripper has handed over everything owed
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (stripped_q.size() != 0) @(posedge aclk);
        drain_holds++;
    endtask

    // One random text: mostly well-formed comments and runs, sometimes cut off inside a comment
    task automatic send_text();
        int  n_tok;
        int  kind;
        int  len;
        bit  cut;
        n_tok = $urandom_range(0, 6);
        cut   = 1'b0;
        for (int t = 0; t < n_tok && !cut; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                len = $urandom_range(1, 4);
                repeat (len) send_byte(pick_plain(), 1'b0);
            end else if (kind < 50) begin
                send_byte(CH_SLASH, 1'b0);
                send_byte(CH_STAR, 1'b0);
                send_body();
                send_byte(CH_STAR, 1'b0);
                send_byte(CH_SLASH, 1'b0);
            end else if (kind < 62) begin
                send_byte(CH_SLASH, 1'b0);
                send_byte(CH_SLASH, 1'b0);
                send_body();
                send_byte(CH_NEWLINE, 1'b0);
            end else if (kind < 74) begin
                send_byte(CH_OPEN, 1'b0);
                send_byte(CH_STAR, 1'b0);
                send_body();
                send_byte(CH_STAR, 1'b0);
                send_byte(CH_CLOSE, 1'b0);
            end else if (kind < 84) begin
                send_byte(($urandom_range(0, 1) == 0) ? CH_SLASH : CH_OPEN, 1'b0);
                send_byte(pick_plain(), 1'b0);
            end else begin
                // Open a comment and end the text inside it
                case ($urandom_range(0, 2))
                    0: begin send_byte(CH_SLASH, 1'b0); send_byte(CH_STAR, 1'b0); end
                    1: begin send_byte(CH_SLASH, 1'b0); send_byte(CH_SLASH, 1'b0); end
                    default: begin send_byte(CH_OPEN, 1'b0); send_byte(CH_STAR, 1'b0); end
                endcase
                send_body();
                cut = 1'b1;
            end
        end
        send_byte(pick_body(), 1'b1);
        texts_sent++;
    endtask

    // Master side: check each transaction against the oldest expectation, then stall at random
    always @(posedge aclk) begin
        strip_res_t exp_res;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (stripped_q.size() == 0) begin
                    $error("unexpected result: out_byte %h has_byte %b end_of_text %b",
                           m_tdata, m_tuser[0], m_tlast);
                    err_cnt++;
                end else begin
                    exp_res = stripped_q.pop_front();
                    res_checked++;
                    if (m_tdata !== exp_res.data) begin
                        $error("out_byte mismatch: expected %h, actual %h", exp_res.data, m_tdata);
                        err_cnt++;
                    end
                    if (m_tuser[0] !== exp_res.has) begin
                        $error("has_byte mismatch: expected %b, actual %b",
                               exp_res.has, m_tuser[0]);
                        err_cnt++;
                    end
                    if (m_tlast !== exp_res.eot) begin
                        $error("end_of_text mismatch: expected %b, actual %b",
                               exp_res.eot, m_tlast);
                        err_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) stall_left--;
                m_tready <= (stall_left == 0) && ($urandom_range(0, 3) != 0 || !idle_on);
            end
        end
    end

    // Count cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL comment_stripper");
        $finish;
    end

    initial begin
        // Directed rows: plain bytes and extremes, each comment kind, end-of-text cases
        dir_tbl[0]  = '{8'h61, 1'b0, 1'b1, 2'd1, '{8'h61, 1'b1, 1'b0}, NO_RES};
        dir_tbl[1]  = '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_RES};
        dir_tbl[2]  = '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0}, NO_RES};
        dir_tbl[3]  = '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[4]  = '{CH_STAR,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[5]  = '{CH_STAR,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[6]  = '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[7]  = '{CH_OPEN,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[8]  = '{CH_STAR,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[9]  = '{CH_STAR,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[10] = '{CH_CLOSE,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[11] = '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[12] = '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[13] = '{CH_NEWLINE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[14] = '{CH_OPEN,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[15] = '{8'h62, 1'b0, 1'b1, 2'd2, '{CH_OPEN, 1'b1, 1'b0}, '{8'h62, 1'b1, 1'b0}};
        dir_tbl[16] = '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        // Held slash released, then a final open paren passes as plain text
        dir_tbl[17] = '{CH_OPEN, 1'b1, 1'b1, 2'd2,
                        '{CH_SLASH, 1'b1, 1'b0}, '{CH_OPEN, 1'b1, 1'b1}};
        dir_tbl[18] = '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[19] = '{CH_STAR,    1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        // Text ends inside a block comment: the final byte comes out
        dir_tbl[20] = '{8'h7A, 1'b1, 1'b1, 2'd1, '{8'h7A, 1'b1, 1'b1}, NO_RES};
        dir_tbl[21] = '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        dir_tbl[22] = '{CH_SLASH,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES};
        // Text ends inside a line comment: bare end marker
        dir_tbl[23] = '{8'h6B, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NO_RES};
        // One-byte text made of an open paren
        dir_tbl[24] = '{CH_OPEN, 1'b1, 1'b1, 2'd1, '{CH_OPEN, 1'b1, 1'b1}, NO_RES};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            drive_byte(dir_tbl[i].chr, dir_tbl[i].lst);
            strip_step(dir_tbl[i].chr, dir_tbl[i].lst);
            if (dir_tbl[i].typed) begin
                if (dir_tbl[i].n_res > 0) stripped_q = {stripped_q, dir_tbl[i].r0};
                if (dir_tbl[i].n_res > 1) stripped_q = {stripped_q, dir_tbl[i].r1};
            end else begin
                push_step_results();
            end
        end
        texts_sent = 4;
        hold_until_drained();

        // Random texts, with idle-free stretches and occasional full drains
        while (bytes_sent < DIR_ROWS + RAND_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) hold_until_drained();
            send_text();
        end
        s_tvalid <= 1'b0;

        while (stripped_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d texts, checked %0d results, drained %0d times.",
                 bytes_sent, texts_sent, res_checked, drain_holds);
        if (err_cnt == 0) begin
            $display("PASS comment_stripper");
        end else begin
            $display("FAIL comment_stripper");
        end
        $finish;
    end

endmodule
